// ===== rtl/tssl_pkg.sv =====
// Shared types and constants for the torque saturation and slew limiter.
// Used by the other modules in rtl/ except tssl_ram; depends on nothing else.
package tssl_pkg;

    // Field widths of the request and response words.
    localparam int CMD_W    = 2;
    localparam int JOINT_W  = 4;
    localparam int TORQUE_W = 32;
    localparam int LIMIT_W  = 31;
    localparam int DT_W     = 24;
    localparam int STATUS_W = 3;
    localparam int PROD_W   = LIMIT_W + DT_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STAGE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_INIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIM      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_VIOL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADLIM   = 3'd5;

    // Result queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic [JOINT_W-1:0]         joint;
        logic signed [TORQUE_W-1:0] torque_value;
        logic [LIMIT_W-1:0]         rate_limit;
        logic [DT_W-1:0]            step_time;
        logic                       last_joint;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic [JOINT_W-1:0]         joint_out;
        logic signed [TORQUE_W-1:0] filtered_torque;
        logic                       last_out;
    } rsp_t;

endpackage

// ===== rtl/tssl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
// Stands alone; depends on no package or other module.
module tssl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tssl_outq.sv =====
// Small result queue that decouples the pipeline from a stalling receiver.
// Depends on tssl_pkg for the response word type and queue geometry.
module tssl_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tssl_pkg::rsp_t          push_word,
    output logic [tssl_pkg::OQ_CNT_W-1:0] count,
    output logic                    out_valid,
    input  logic                    out_stall,
    output tssl_pkg::rsp_t          out_word
);
    import tssl_pkg::*;

    rsp_t                entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg;
    logic [OQ_PTR_W-1:0] rd_ptr_reg;
    logic [OQ_CNT_W-1:0] count_reg;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && !out_stall;

    // Storage for queued words.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + OQ_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - OQ_CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/torque_saturation_slew_limiter_core.sv =====
// Per-joint torque saturation and slew-rate limiter, top level.
// Depends on tssl_pkg, tssl_ram and tssl_outq.
//
// Usage: each request word addresses one joint. Load writes the joint's
// absolute and rate limits, stage places an initial torque for a vector
// reset that commits on the word marked last, and filter clamps a torque to
// the absolute limit, limits its step from the stored torque to
// (rate * dt) >> 24, stores and returns it. Every request word gives
// exactly one response word, in order.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. An accepted word passes through stage 1, stage 2 and the result queue.
// Throughput is one word per cycle. The only pauses are while a stage word
// marked last is in stage 1 or stage 2, while the vector commit flips the
// torque bank selectors, and while the four-entry result queue, counted
// together with words still in the two pipeline stages, is full.
// State lives in two RAMs: limits (one row per joint) and torques (two banks
// per joint, current and staged); a per-joint selector picks the bank.
// Reset clears the pipeline, the queue, the selectors and the staging
// bookkeeping and leaves the block uninitialized; RAM contents are kept.
// When the receiver stalls, results wait in the queue and request stall
// rises once the queue can no longer take the words in flight.
module torque_saturation_slew_limiter_core #(
    parameter int NUM_JOINTS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  tssl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tssl_pkg::rsp_t rsp
);
    import tssl_pkg::*;

    localparam int JW     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int TAW    = JW + 1;
    localparam int LMW    = 2 * LIMIT_W;
    localparam int SUM_W  = OQ_CNT_W + 1;
    localparam logic [JOINT_W-1:0] JOINT_MAX = JOINT_W'(NUM_JOINTS - 1);

    // Input stage.
    logic           acc;
    logic           in_range;
    logic [JW-1:0]  jidx;
    logic           slot;
    logic           commit_pend;
    logic [SUM_W-1:0] inflight_sum;
    logic [OQ_CNT_W-1:0] oq_count;

    // Pipeline registers.
    logic           s1_valid_reg;
    req_t           s1_req_reg;
    logic           s1_slot_reg;
    logic           s2_valid_reg;
    req_t           s2_req_reg;
    logic           s2_slot_reg;
    logic signed [TORQUE_W-1:0] s2_sat_reg;
    logic [LIMIT_W-1:0]         s2_delta_reg;
    logic signed [TORQUE_W-1:0] s2_prev_reg;
    logic                       s2_viol_reg;

    // Write-back registers used for forwarding.
    logic                twb_valid_reg;
    logic [TAW-1:0]      twb_addr_reg;
    logic [TORQUE_W-1:0] twb_data_reg;
    logic                lwb_valid_reg;
    logic [JW-1:0]       lwb_addr_reg;
    logic [LMW-1:0]      lwb_data_reg;

    // Control state.
    logic [NUM_JOINTS-1:0] sel_reg;
    logic [NUM_JOINTS-1:0] sel_next;
    logic [NUM_JOINTS-1:0] mask_reg;
    logic [NUM_JOINTS-1:0] mask_next;
    logic                  viol_reg;
    logic                  viol_next;
    logic                  dimbad_reg;
    logic                  dimbad_next;
    logic                  init_reg;
    logic                  init_next;

    // RAM ports.
    logic [TAW-1:0]      t_raddr;
    logic [TORQUE_W-1:0] t_rdata;
    logic                t_we;
    logic [TAW-1:0]      t_waddr;
    logic [TORQUE_W-1:0] t_wdata;
    logic [LMW-1:0]      l_rdata;
    logic                l_we;
    logic [LMW-1:0]      l_wdata;

    // Stage 1 signals.
    logic [JW-1:0]              s1_jidx;
    logic [TAW-1:0]             s1_taddr;
    logic [LMW-1:0]             s1_lim;
    logic [LIMIT_W-1:0]         s1_abs;
    logic [LIMIT_W-1:0]         s1_slew;
    logic signed [TORQUE_W-1:0] s1_prev;
    logic signed [TORQUE_W-1:0] s1_pos;
    logic signed [TORQUE_W-1:0] s1_neg;
    logic signed [TORQUE_W-1:0] s1_sat;
    logic [TORQUE_W:0]          s1_mag;
    logic                       s1_viol;
    logic [PROD_W-1:0]          s1_prod;

    // Stage 2 signals.
    logic [JW-1:0]              s2_jidx;
    logic                       s2_in_range;
    logic [TAW-1:0]             s2_taddr;
    logic signed [TORQUE_W-1:0] s2_prev;
    logic signed [TORQUE_W:0]   s2_hi;
    logic signed [TORQUE_W:0]   s2_lo;
    logic signed [TORQUE_W:0]   s2_sat_e;
    logic signed [TORQUE_W:0]   s2_res_e;
    logic [NUM_JOINTS-1:0]      s2_bit;
    logic                       s2_dup;
    logic [NUM_JOINTS-1:0]      mask_acc;
    logic                       viol_acc;
    logic                       dimbad_acc;
    rsp_t                       s2_rsp;

    // Acceptance and stall: hold off while a vector commit is in flight or
    // the queue could not take every word already in the pipeline.
    assign inflight_sum = {1'b0, oq_count} + SUM_W'(s1_valid_reg) + SUM_W'(s2_valid_reg);
    assign commit_pend  = (s1_valid_reg && s1_req_reg.cmd == CMD_STAGE && s1_req_reg.last_joint)
                       || (s2_valid_reg && s2_req_reg.cmd == CMD_STAGE && s2_req_reg.last_joint);
    assign req_stall    = commit_pend || (inflight_sum >= SUM_W'(OQ_DEPTH));
    assign acc          = req_valid && !req_stall;

    // Read addresses: stage words go to the bank that is not current.
    assign jidx     = req.joint[JW-1:0];
    assign in_range = (req.joint <= JOINT_MAX);
    assign slot     = (in_range ? sel_reg[jidx] : 1'b0) ^ (req.cmd == CMD_STAGE);
    assign t_raddr  = {slot, jidx};

    tssl_ram #(
        .WIDTH (TORQUE_W),
        .DEPTH (1 << TAW)
    ) u_torque_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    tssl_ram #(
        .WIDTH (LMW),
        .DEPTH (1 << JW)
    ) u_limit_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (s2_jidx),
        .wdata (l_wdata),
        .raddr (jidx),
        .rdata (l_rdata)
    );

    // Stage 1: forward recent writes, clamp, and form the allowed step.
    always_comb
    begin
        s1_jidx  = s1_req_reg.joint[JW-1:0];
        s1_taddr = {s1_slot_reg, s1_jidx};
        if (l_we && s2_jidx == s1_jidx)
        begin
            s1_lim = l_wdata;
        end
        else if (lwb_valid_reg && lwb_addr_reg == s1_jidx)
        begin
            s1_lim = lwb_data_reg;
        end
        else
        begin
            s1_lim = l_rdata;
        end
        s1_abs  = s1_lim[LIMIT_W-1:0];
        s1_slew = s1_lim[LMW-1:LIMIT_W];
        if (twb_valid_reg && twb_addr_reg == s1_taddr)
        begin
            s1_prev = twb_data_reg;
        end
        else
        begin
            s1_prev = t_rdata;
        end
        s1_pos = {1'b0, s1_abs};
        s1_neg = -s1_pos;
        if (s1_req_reg.torque_value > s1_pos)
        begin
            s1_sat = s1_pos;
        end
        else if (s1_req_reg.torque_value < s1_neg)
        begin
            s1_sat = s1_neg;
        end
        else
        begin
            s1_sat = s1_req_reg.torque_value;
        end
        if (s1_req_reg.torque_value[TORQUE_W-1])
        begin
            s1_mag = (TORQUE_W+1)'(0) - {1'b1, s1_req_reg.torque_value};
        end
        else
        begin
            s1_mag = {1'b0, s1_req_reg.torque_value};
        end
        s1_viol = (s1_mag > {2'b00, s1_abs});
        s1_prod = PROD_W'(s1_slew) * PROD_W'(s1_req_reg.step_time);
    end

    // Stage 2: step limit, status, state update and write-back.
    always_comb
    begin
        s2_jidx     = s2_req_reg.joint[JW-1:0];
        s2_in_range = (s2_req_reg.joint <= JOINT_MAX);
        s2_taddr    = {s2_slot_reg, s2_jidx};
        if (twb_valid_reg && twb_addr_reg == s2_taddr)
        begin
            s2_prev = twb_data_reg;
        end
        else
        begin
            s2_prev = s2_prev_reg;
        end
        s2_hi    = {s2_prev[TORQUE_W-1], s2_prev} + {2'b00, s2_delta_reg};
        s2_lo    = {s2_prev[TORQUE_W-1], s2_prev} - {2'b00, s2_delta_reg};
        s2_sat_e = {s2_sat_reg[TORQUE_W-1], s2_sat_reg};
        if (s2_sat_e > s2_hi)
        begin
            s2_res_e = s2_hi;
        end
        else if (s2_sat_e < s2_lo)
        begin
            s2_res_e = s2_lo;
        end
        else
        begin
            s2_res_e = s2_sat_e;
        end

        s2_bit     = s2_in_range ? (NUM_JOINTS'(1) << s2_jidx) : '0;
        s2_dup     = ((mask_reg & s2_bit) != '0);
        mask_acc   = mask_reg;
        viol_acc   = viol_reg;
        dimbad_acc = dimbad_reg;

        sel_next    = sel_reg;
        mask_next   = mask_reg;
        viol_next   = viol_reg;
        dimbad_next = dimbad_reg;
        init_next   = init_reg;
        t_we        = 1'b0;
        t_waddr     = s2_taddr;
        t_wdata     = s2_req_reg.torque_value;
        l_we        = 1'b0;
        l_wdata     = {s2_req_reg.rate_limit, s2_req_reg.torque_value[LIMIT_W-1:0]};

        s2_rsp.status          = ST_OK;
        s2_rsp.joint_out       = s2_req_reg.joint;
        s2_rsp.filtered_torque = '0;
        s2_rsp.last_out        = s2_req_reg.last_joint;

        if (s2_valid_reg)
        begin
            case (s2_req_reg.cmd)
                CMD_LOAD:
                begin
                    if (!s2_in_range)
                    begin
                        s2_rsp.status = ST_DIM;
                    end
                    else if (s2_req_reg.torque_value <= 0 || s2_req_reg.rate_limit == '0)
                    begin
                        s2_rsp.status = ST_BADLIM;
                    end
                    else
                    begin
                        l_we = 1'b1;
                    end
                end
                CMD_STAGE:
                begin
                    if (!s2_in_range || s2_dup)
                    begin
                        dimbad_acc    = 1'b1;
                        s2_rsp.status = ST_DIM;
                    end
                    else
                    begin
                        t_we     = 1'b1;
                        mask_acc = mask_reg | s2_bit;
                        if (s2_viol_reg)
                        begin
                            viol_acc      = 1'b1;
                            s2_rsp.status = ST_VIOL;
                        end
                    end
                    if (s2_req_reg.last_joint)
                    begin
                        // Close the vector; a clean one flips every bank.
                        if (dimbad_acc || !(&mask_acc))
                        begin
                            s2_rsp.status = ST_DIM;
                        end
                        else if (viol_acc)
                        begin
                            s2_rsp.status = ST_VIOL;
                        end
                        else
                        begin
                            s2_rsp.status = ST_OK;
                            sel_next      = ~sel_reg;
                            init_next     = 1'b1;
                        end
                        mask_next   = '0;
                        viol_next   = 1'b0;
                        dimbad_next = 1'b0;
                    end
                    else
                    begin
                        mask_next   = mask_acc;
                        viol_next   = viol_acc;
                        dimbad_next = dimbad_acc;
                    end
                end
                CMD_FILTER:
                begin
                    if (!init_reg)
                    begin
                        s2_rsp.status = ST_NOT_INIT;
                    end
                    else if (!s2_in_range)
                    begin
                        s2_rsp.status = ST_DIM;
                    end
                    else if (s2_req_reg.step_time == '0)
                    begin
                        s2_rsp.status = ST_DT;
                    end
                    else
                    begin
                        t_we                   = 1'b1;
                        t_wdata                = s2_res_e[TORQUE_W-1:0];
                        s2_rsp.filtered_torque = s2_res_e[TORQUE_W-1:0];
                    end
                end
                default:
                begin
                    s2_rsp.status = ST_OK;
                end
            endcase
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        s1_req_reg   <= req;
        s1_slot_reg  <= slot;
        s2_req_reg   <= s1_req_reg;
        s2_slot_reg  <= s1_slot_reg;
        s2_sat_reg   <= s1_sat;
        s2_delta_reg <= s1_prod[PROD_W-1:DT_W];
        s2_prev_reg  <= s1_prev;
        s2_viol_reg  <= s1_viol;
        twb_addr_reg <= t_waddr;
        twb_data_reg <= t_wdata;
        lwb_addr_reg <= s2_jidx;
        lwb_data_reg <= l_wdata;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            twb_valid_reg <= 1'b0;
            lwb_valid_reg <= 1'b0;
            sel_reg       <= '0;
            mask_reg      <= '0;
            viol_reg      <= 1'b0;
            dimbad_reg    <= 1'b0;
            init_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= acc;
            s2_valid_reg  <= s1_valid_reg;
            twb_valid_reg <= t_we;
            lwb_valid_reg <= l_we;
            sel_reg       <= sel_next;
            mask_reg      <= mask_next;
            viol_reg      <= viol_next;
            dimbad_reg    <= dimbad_next;
            init_reg      <= init_next;
        end
    end

    tssl_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_word (s2_rsp),
        .count     (oq_count),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_word  (rsp)
    );

    // The queue plus the pipeline never hold more words than the queue fits.
    assert property (@(posedge clk) disable iff (!rst_n)
        inflight_sum <= SUM_W'(OQ_DEPTH))
        else $error("result queue overcommitted");

    // A closing stage word is never followed directly by another word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_req_reg.cmd == CMD_STAGE && s1_req_reg.last_joint)
        |=> !s1_valid_reg)
        else $error("word accepted behind a pending vector commit");

    // Initialization only comes from a closing stage word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(init_reg) |-> $past(s2_valid_reg && s2_req_reg.cmd == CMD_STAGE
                                  && s2_req_reg.last_joint))
        else $error("initialized set without a vector commit");

    // Bank selectors change only all together on a commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sel_reg) |-> (sel_reg == ~$past(sel_reg)))
        else $error("torque bank selectors changed partially");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for torque_saturation_slew_limiter_core.
// Depends on tssl_pkg for the word types and the command and status codes.
// A directed table, then random load, stage, filter and unused-command traffic, checked in order.
module tb_top;
    import tssl_pkg::*;

    localparam int NJ           = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_ITEMS   = 800;
    localparam int HOLD_CYCLES  = 60;
    localparam int MAX_REPORTS  = 10;

    // The fourth command code does nothing in the block.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        req_t word;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow state of the limiter.
    logic [30:0]        lim_abs [NJ];
    logic [30:0]        lim_rate [NJ];
    logic signed [31:0] trq_prev [NJ];
    logic signed [31:0] trq_staged [NJ];
    bit                 torque_ready = 1'b0;
    logic [15:0]        stage_mask   = '0;
    bit                 stage_viol   = 1'b0;
    bit                 stage_dim    = 1'b0;

    rsp_t      pending_rsp [$];
    plan_row_t plan_q [$];
    int        mismatch_cnt = 0;
    int        n_items      = 0;

    // Coordination between the sender and the receiver.
    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_on   = 1'b0;
    bit hold_done = 1'b0;
    bit paused    = 1'b0;

    torque_saturation_slew_limiter_core #(
        .NUM_JOINTS(NJ)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Computes the response to one accepted word and updates the shadow state.
    function automatic rsp_t limit_torque(input req_t w);
        rsp_t               r;
        logic signed [63:0] trq;
        logic signed [63:0] lim;
        logic signed [63:0] mag;
        logic signed [63:0] slew;
        logic signed [63:0] prev;
        logic signed [63:0] sat;
        logic [63:0]        prod;
        logic [15:0]        full;
        r.status          = ST_OK;
        r.joint_out       = w.joint;
        r.filtered_torque = '0;
        r.last_out        = w.last_joint;
        trq  = {{32{w.torque_value[31]}}, w.torque_value};
        full = 16'((1 << NJ) - 1);
        case (w.cmd)
            CMD_LOAD:
            begin
                if (w.joint >= NJ)
                    r.status = ST_DIM;
                else if (trq <= 0 || w.rate_limit == '0)
                    r.status = ST_BADLIM;
                else
                begin
                    lim_abs[w.joint]  = w.torque_value[30:0];
                    lim_rate[w.joint] = w.rate_limit;
                end
            end
            CMD_STAGE:
            begin
                // Out of range or repeated joints doom the vector.
                if (w.joint >= NJ || stage_mask[w.joint])
                begin
                    stage_dim = 1'b1;
                    r.status  = ST_DIM;
                end
                else
                begin
                    mag = (trq < 0) ? -trq : trq;
                    trq_staged[w.joint] = w.torque_value;
                    stage_mask[w.joint] = 1'b1;
                    if (mag > $signed({33'd0, lim_abs[w.joint]}))
                    begin
                        stage_viol = 1'b1;
                        r.status   = ST_VIOL;
                    end
                end
                // The word marked last closes the vector and commits it if clean.
                if (w.last_joint)
                begin
                    if (stage_dim || stage_mask != full)
                        r.status = ST_DIM;
                    else if (stage_viol)
                        r.status = ST_VIOL;
                    else
                    begin
                        for (int k = 0; k < NJ; k++)
                            trq_prev[k] = trq_staged[k];
                        torque_ready = 1'b1;
                        r.status     = ST_OK;
                    end
                    stage_mask = '0;
                    stage_viol = 1'b0;
                    stage_dim  = 1'b0;
                end
            end
            CMD_FILTER:
            begin
                if (!torque_ready)
                    r.status = ST_NOT_INIT;
                else if (w.joint >= NJ)
                    r.status = ST_DIM;
                else if (w.step_time == '0)
                    r.status = ST_DT;
                else
                begin
                    // Clamp to the absolute limit, then to the allowed step.
                    lim  = {33'd0, lim_abs[w.joint]};
                    prod = 64'(lim_rate[w.joint]) * 64'(w.step_time);
                    slew = $signed(prod >> 24);
                    prev = {{32{trq_prev[w.joint][31]}}, trq_prev[w.joint]};
                    sat  = trq;
                    if (sat > lim)
                        sat = lim;
                    if (sat < -lim)
                        sat = -lim;
                    if (sat > prev + slew)
                        sat = prev + slew;
                    if (sat < prev - slew)
                        sat = prev - slew;
                    trq_prev[w.joint] = sat[31:0];
                    r.filtered_torque = sat[31:0];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void plan_row(input logic [CMD_W-1:0] cmd, input logic [3:0] j,
                                     input logic [31:0] trq, input logic [30:0] rate,
                                     input logic [23:0] step, input logic last,
                                     input bit typed, input logic [STATUS_W-1:0] st);
        plan_row_t p;
        p.word.cmd               = cmd;
        p.word.joint             = j;
        p.word.torque_value      = trq;
        p.word.rate_limit        = rate;
        p.word.step_time         = step;
        p.word.last_joint        = last;
        p.typed                  = typed;
        p.want.status            = st;
        p.want.joint_out         = j;
        p.want.filtered_torque   = '0;
        p.want.last_out          = last;
        plan_q.push_back(p);
    endfunction

    function automatic req_t rand_word(input logic [CMD_W-1:0] cmd);
        req_t w;
        w.cmd          = cmd;
        w.joint        = 4'($urandom_range(NJ - 1));
        w.torque_value = $urandom();
        w.rate_limit   = 31'($urandom());
        w.step_time    = 24'($urandom());
        w.last_joint   = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic logic [31:0] torque_within(input logic [30:0] lim);
        logic [31:0] mag;
        mag = $urandom_range(32'(lim), 0);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic void note_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Presents one word, holds it until accepted, then records its response.
    task automatic offer(input req_t w, input bit typed, input rsp_t want);
        rsp_t got;
        while (!quiet && !hold_on && $urandom_range(99) < 23)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        got = limit_torque(w);
        pending_rsp.push_back(typed ? want : got);
    endtask

    task automatic drain_wait();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Random-part word: counts it unless its command is unused, and triggers the pressure phases.
    task automatic feed(input req_t w);
        offer(w, 1'b0, '0);
        if (w.cmd != CMD_UNUSED)
            n_items++;
        quiet = (n_items >= 380 && n_items < 560);
        if (n_items == 250 && !hold_done)
        begin
            hold_done = 1'b1;
            hold_req  = 1'b1;
        end
        if (n_items == 500 && !paused)
        begin
            paused = 1'b1;
            drain_wait();
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a quiet stretch.
    initial
    begin : rsp_side
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_on  = 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
                hold_on = 1'b0;
            end
            rsp_stall <= !quiet && ($urandom_range(99) < 23);
        end
    end

    // Response checker: in-order compare against the oldest expectation.
    always @(posedge clk)
    begin : rsp_check
        rsp_t w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                note_error($sformatf("unexpected word: st=%0d j=%0d trq=%h last=%0d",
                                     rsp.status, rsp.joint_out, rsp.filtered_torque,
                                     rsp.last_out));
            else
            begin
                w = pending_rsp.pop_front();
                if (rsp.status !== w.status || rsp.joint_out !== w.joint_out ||
                    rsp.filtered_torque !== w.filtered_torque || rsp.last_out !== w.last_out)
                    note_error($sformatf(
                        "mismatch: want st=%0d j=%0d trq=%h last=%0d, got st=%0d j=%0d trq=%h last=%0d",
                        w.status, w.joint_out, w.filtered_torque, w.last_out,
                        rsp.status, rsp.joint_out, rsp.filtered_torque, rsp.last_out));
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stim
        int   pick;
        int   sub;
        int   burst;
        int   variant;
        int   k;
        int   s;
        int   tmp;
        int   order [NJ];
        req_t w;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: errors before init, limit loads, doomed and clean vectors, then filter checks.
        plan_row(CMD_FILTER, 4'd15, 32'h1234_5678, 31'd0, 24'd0, 1'b0, 1'b1, ST_NOT_INIT);
        plan_row(CMD_LOAD, 4'd8, 32'h0000_0100, 31'd1, 24'd0, 1'b0, 1'b1, ST_DIM);
        plan_row(CMD_LOAD, 4'd0, 32'h0000_0000, 31'd1, 24'd0, 1'b0, 1'b1, ST_BADLIM);
        plan_row(CMD_LOAD, 4'd1, 32'h8000_0000, 31'd0, 24'd0, 1'b0, 1'b1, ST_BADLIM);
        plan_row(CMD_LOAD, 4'd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1,
                 ST_OK);
        plan_row(CMD_LOAD, 4'd1, 32'h0000_0001, 31'd1, 24'd0, 1'b0, 1'b1, ST_OK);
        for (k = 2; k < NJ; k++)
            plan_row(CMD_LOAD, 4'(k), 32'h0010_0000, 31'h00A0_0000, 24'd0, 1'b0, 1'b1, ST_OK);
        plan_row(CMD_STAGE, 4'd2, 32'h0020_0000, 31'd0, 24'd0, 1'b0, 1'b1, ST_VIOL);
        plan_row(CMD_STAGE, 4'd2, 32'h0000_0000, 31'd0, 24'd0, 1'b0, 1'b1, ST_DIM);
        plan_row(CMD_STAGE, 4'd4, 32'h0000_0000, 31'd0, 24'd0, 1'b1, 1'b1, ST_DIM);
        plan_row(CMD_UNUSED, 4'd5, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1,
                 ST_OK);
        plan_row(CMD_STAGE, 4'd0, 32'h8000_0001, 31'd0, 24'd0, 1'b0, 1'b1, ST_OK);
        plan_row(CMD_STAGE, 4'd1, 32'hFFFF_FFFF, 31'd0, 24'd0, 1'b0, 1'b1, ST_OK);
        plan_row(CMD_STAGE, 4'd2, 32'h0010_0000, 31'd0, 24'd0, 1'b0, 1'b1, ST_OK);
        plan_row(CMD_STAGE, 4'd3, 32'hFFF0_0000, 31'd0, 24'd0, 1'b0, 1'b1, ST_OK);
        for (k = 4; k < NJ - 1; k++)
            plan_row(CMD_STAGE, 4'(k), 32'h0010_0000, 31'd0, 24'd0, 1'b0, 1'b1, ST_OK);
        plan_row(CMD_STAGE, 4'(NJ - 1), 32'h0000_0000, 31'd0, 24'd0, 1'b1, 1'b1, ST_OK);
        plan_row(CMD_FILTER, 4'd0, 32'h7FFF_FFFF, 31'd0, 24'hFF_FFFF, 1'b0, 1'b0, ST_OK);
        plan_row(CMD_FILTER, 4'd2, 32'h0000_1000, 31'd0, 24'd0, 1'b0, 1'b1, ST_DT);
        plan_row(CMD_FILTER, 4'd12, 32'h0000_1000, 31'd0, 24'd5, 1'b0, 1'b1, ST_DIM);
        plan_row(CMD_FILTER, 4'd7, 32'h7FFF_FFFF, 31'd0, 24'd1, 1'b1, 1'b0, ST_OK);
        foreach (plan_q[i])
            offer(plan_q[i].word, plan_q[i].typed, plan_q[i].want);
        drain_wait();

        // Random part: mostly filter bursts, with limit reloads, stage vectors and unused-command words.
        while (n_items < RAND_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                w   = rand_word(CMD_LOAD);
                sub = $urandom_range(9);
                if (sub == 0)
                    w.joint = 4'($urandom_range(15, NJ));
                else if (sub == 1)
                    w.torque_value = $urandom_range(1) ? 32'd0 : (32'h8000_0000 | $urandom());
                else if (sub == 2)
                    w.rate_limit = '0;
                else if (sub < 6)
                begin
                    w.torque_value = $urandom_range(32'h0040_0000, 1);
                    w.rate_limit   = 31'($urandom_range(32'h0100_0000, 1));
                end
                else
                begin
                    w.torque_value = $urandom_range(32'h7FFF_FFFF, 1);
                    w.rate_limit   = 31'($urandom_range(32'h7FFF_FFFF, 1));
                end
                feed(w);
            end
            else if (pick < 20)
            begin
                // One reset vector in shuffled joint order, sometimes broken.
                for (k = 0; k < NJ; k++)
                    order[k] = k;
                for (k = NJ - 1; k > 0; k--)
                begin
                    s        = $urandom_range(k);
                    tmp      = order[k];
                    order[k] = order[s];
                    order[s] = tmp;
                end
                variant = $urandom_range(9);
                for (k = 0; k < NJ; k++)
                begin
                    if (variant == 4 && k == 2)
                        continue;
                    w              = rand_word(CMD_STAGE);
                    w.joint        = 4'(order[k]);
                    w.torque_value = torque_within(lim_abs[order[k]]);
                    w.last_joint   = (k == NJ - 1);
                    if (variant == 1 && k == 3)
                    begin
                        w.torque_value = 32'(lim_abs[order[k]]) + 32'd1;
                        if ($urandom_range(1))
                            w.torque_value = -w.torque_value;
                    end
                    if (variant == 2 && k == 5)
                        w.joint = 4'(order[2]);
                    if (variant == 3 && k == 4)
                        w.joint = 4'($urandom_range(15, NJ));
                    if (variant == 5 && k == NJ - 1)
                        w.last_joint = 1'b0;
                    feed(w);
                end
            end
            else if (pick < 23)
                feed(rand_word(CMD_UNUSED));
            else
            begin
                burst = $urandom_range(16, 1);
                repeat (burst)
                begin
                    w = rand_word(CMD_FILTER);
                    if ($urandom_range(9) == 0)
                        w.joint = 4'($urandom_range(15, NJ));
                    sub = $urandom_range(3);
                    if (sub == 1 && w.joint < NJ)
                        w.torque_value = torque_within(lim_abs[w.joint]);
                    else if (sub == 2 && w.joint < NJ)
                        w.torque_value = trq_prev[w.joint] + 32'($signed(20'($urandom())));
                    else if (sub == 3)
                        w.torque_value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    sub = $urandom_range(9);
                    if (sub == 0)
                        w.step_time = '0;
                    else if (sub < 4)
                        w.step_time = 24'($urandom_range(255, 1));
                    feed(w);
                end
            end
        end

        drain_wait();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tssl_pkg.sv
rtl/tssl_ram.sv
rtl/tssl_outq.sv
rtl/torque_saturation_slew_limiter_core.sv
tb/tb_top.sv
